/* rtl/core/plsu_pkg.sv */
`timescale 1ns / 1ps

package plsu_pkg;

    localparam int DATA_W = 32;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ERASE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SORT   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_SWAP,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;   // odd/even pairing for the sort rounds
    } cell_ctrl_t;

endpackage

/* rtl/core/plsu_cell.sv */
`timescale 1ns / 1ps

module plsu_cell
    import plsu_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl_i,
    input  logic [CNT_W-1:0]  pos_i,
    input  logic [CNT_W-1:0]  count_i,
    input  logic [DATA_W-1:0] value_i,
    input  logic [DATA_W-1:0] head_i,
    input  logic [DATA_W-1:0] prev_i,
    input  logic [DATA_W-1:0] next_i,
    input  logic              gt_left_i,
    output logic [DATA_W-1:0] data_o,
    output logic              gt_o
);

    localparam logic [CNT_W:0] IDX_X  = (CNT_W+1)'(IDX);
    localparam logic [CNT_W:0] IDX_P1 = (CNT_W+1)'(IDX + 1);
    localparam logic           PARITY = 1'(IDX % 2);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [CNT_W:0]    pos_x;
    logic [CNT_W:0]    cnt_x;
    logic              is_left;

    assign pos_x   = {1'b0, pos_i};
    assign cnt_x   = {1'b0, count_i};
    assign is_left = (PARITY == ctrl_i.phase);
    assign gt_o    = $signed(data_reg) > $signed(next_i);
    assign data_o  = data_reg;

    always_comb begin
        data_next = data_reg;
        case (ctrl_i.op)
            CELL_INSERT: begin
                if (IDX_X == pos_x) begin
                    data_next = value_i;
                end else if (IDX_X > pos_x) begin
                    data_next = prev_i;
                end
            end
            CELL_ERASE: begin
                if (IDX_X >= pos_x) begin
                    data_next = next_i;
                end
            end
            CELL_SWAP: begin
                // strict compare keeps equal values in order
                if (is_left) begin
                    if (IDX_P1 < cnt_x && gt_o) begin
                        data_next = next_i;
                    end
                end else if (IDX != 0 && IDX_X < cnt_x && gt_left_i) begin
                    data_next = prev_i;
                end
            end
            CELL_ROTATE: begin
                if (IDX_P1 < cnt_x) begin
                    data_next = next_i;
                end else if (IDX_P1 == cnt_x) begin
                    data_next = head_i;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

/* rtl/core/positional_list_store_unit.sv */
`timescale 1ns / 1ps

// Positional list store: an ordered list of up to MAX_ENTRIES signed 32-bit
// values held in a row of cells, one value per cell.
// Request beats arrive on s_* (insert at a position, erase at a position,
// sort ascending, dump); result beats leave on m_*, m_tlast on the final
// beat of each request. Every result carries status, count and empty flag.
// Per request:
//  - insert, erase and a dump of an empty list: one result, valid the cycle
//    after the request beat; all cells shift together as the beat is taken.
//  - sort: odd-even transposition over the cells, one round per cycle,
//    count rounds, then the result is loaded into the output register.
//  - dump: count beats, the first loaded from the head cell in the dump state,
//    then one per cycle while m_tready is high; the cells rotate towards
//    the head, and after count steps the list is back in order.
// A new request is taken once the block is idle and the output register is
// empty or being drained that cycle; a result still waiting on m_tready
// holds it off. When the receiver stalls, the result beat holds and a dump
// pauses.
// Reset (aresetn low, synchronous) empties the list and drops any result;
// cell contents are not cleared, as only cells below the count are read.
module positional_list_store_unit
    import plsu_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic aclk,
    input  logic aresetn,
    // request: req_type, position, value
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [((REQ_W + $clog2(MAX_ENTRIES+1) + DATA_W + 7) / 8) * 8 - 1:0] s_tdata,
    // result: status, element, count, is_empty
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [((STAT_W + DATA_W + $clog2(MAX_ENTRIES+1) + 1 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                 m_tuser,   // element_valid
    output logic                 m_tlast
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int OUT_B  = STAT_W + DATA_W + CNT_W + 1;
    localparam int OUT_W  = ((OUT_B + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_DUMP
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   idx_reg;      // sort round or dump beat index

    logic               m_tvalid_reg;
    logic [STAT_W-1:0]  m_status_reg;
    logic [DATA_W-1:0]  m_element_reg;
    logic               m_evalid_reg;
    logic [CNT_W-1:0]   m_count_reg;
    logic               m_last_reg;

    logic               out_free;
    logic               out_load;
    logic               acc;
    logic [REQ_W-1:0]   req;
    logic [CNT_W-1:0]   pos;
    logic [DATA_W-1:0]  val;
    logic               ins_bad_pos;
    logic               ins_full;
    logic               era_ok;
    logic               dump_last;
    cell_ctrl_t         ctrl;

    logic [DATA_W-1:0]  cell_q [MAX_ENTRIES];
    logic               cell_gt [MAX_ENTRIES];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign acc      = s_tvalid && s_tready;

    assign req = s_tdata[REQ_W-1:0];
    assign pos = s_tdata[REQ_W +: CNT_W];
    assign val = s_tdata[REQ_W + CNT_W +: DATA_W];

    assign ins_bad_pos = pos > count_reg;
    assign ins_full    = count_reg >= MAX_CNT;
    assign era_ok      = pos < count_reg;
    assign dump_last   = (idx_reg + 1'b1) == count_reg;

    // a result beat is loaded into the output register this cycle
    assign out_load = ((state_reg == ST_IDLE) && acc && (req != REQ_SORT)
                          && !(req == REQ_DUMP && count_reg != '0))
                   || ((state_reg == ST_SORT) && (idx_reg == count_reg))
                   || ((state_reg == ST_DUMP) && out_free);

    // per-cycle command to the cell row
    always_comb begin
        ctrl.op    = CELL_HOLD;
        ctrl.phase = idx_reg[0];
        case (state_reg)
            ST_IDLE: begin
                if (acc && req == REQ_INSERT && !ins_bad_pos && !ins_full) begin
                    ctrl.op = CELL_INSERT;
                end else if (acc && req == REQ_ERASE && era_ok) begin
                    ctrl.op = CELL_ERASE;
                end
            end
            ST_SORT: begin
                if (idx_reg != count_reg) begin
                    ctrl.op = CELL_SWAP;
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    ctrl.op = CELL_ROTATE;
                end
            end
            default: begin
                ctrl.op = CELL_HOLD;
            end
        endcase
    end

    // the cell row; neighbours at the ends see zero
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [DATA_W-1:0] prev_d;
        logic [DATA_W-1:0] next_d;
        logic              gt_left;

        if (g == 0) begin : g_head
            assign prev_d  = '0;
            assign gt_left = 1'b0;
        end else begin : g_body
            assign prev_d  = cell_q[g-1];
            assign gt_left = cell_gt[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_tail
            assign next_d = '0;
        end else begin : g_inner
            assign next_d = cell_q[g+1];
        end

        plsu_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl_i    (ctrl),
            .pos_i     (pos),
            .count_i   (count_reg),
            .value_i   (val),
            .head_i    (cell_q[0]),
            .prev_i    (prev_d),
            .next_i    (next_d),
            .gt_left_i (gt_left),
            .data_o    (cell_q[g]),
            .gt_o      (cell_gt[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (acc) begin
                        m_element_reg <= '0;
                        m_evalid_reg  <= 1'b0;
                        m_last_reg    <= 1'b1;
                        idx_reg       <= '0;
                        case (req)
                            REQ_INSERT: begin
                                if (ins_bad_pos) begin
                                    m_status_reg <= STAT_BAD_POS;
                                    m_count_reg  <= count_reg;
                                end else if (ins_full) begin
                                    m_status_reg <= STAT_FULL;
                                    m_count_reg  <= count_reg;
                                end else begin
                                    m_status_reg <= STAT_OK;
                                    count_reg    <= count_reg + 1'b1;
                                    m_count_reg  <= count_reg + 1'b1;
                                end
                            end
                            REQ_ERASE: begin
                                if (era_ok) begin
                                    m_status_reg <= STAT_OK;
                                    count_reg    <= count_reg - 1'b1;
                                    m_count_reg  <= count_reg - 1'b1;
                                end else begin
                                    m_status_reg <= STAT_BAD_POS;
                                    m_count_reg  <= count_reg;
                                end
                            end
                            REQ_SORT: begin
                                state_reg <= ST_SORT;
                            end
                            REQ_DUMP: begin
                                m_status_reg <= STAT_OK;
                                m_count_reg  <= count_reg;
                                if (count_reg != '0) begin
                                    state_reg <= ST_DUMP;
                                end
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SORT: begin
                    if (idx_reg == count_reg) begin
                        m_status_reg  <= STAT_OK;
                        m_element_reg <= '0;
                        m_evalid_reg  <= 1'b0;
                        m_count_reg   <= count_reg;
                        m_last_reg    <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DUMP: begin
                    if (out_free) begin
                        m_status_reg  <= STAT_OK;
                        m_element_reg <= cell_q[0];
                        m_evalid_reg  <= 1'b1;
                        m_count_reg   <= count_reg;
                        m_last_reg    <= dump_last;
                        idx_reg       <= idx_reg + 1'b1;
                        if (dump_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_evalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = OUT_W'({(m_count_reg == '0), m_count_reg,
                              m_element_reg, m_status_reg});

`ifndef NO_ASSERTIONS
    // the list never grows past its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("list count beyond capacity");

    // the count only moves on an accepted request beat
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready) |=> $stable(count_reg))
        else $error("count changed without a request");

    // sort rounds never run past the element count
    a_sort_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SORT) |-> (idx_reg <= count_reg))
        else $error("sort round counter overran");

    // a beat carrying an element is always an ok dump beat of a non-empty list
    a_elem_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_status_reg == STAT_OK && m_count_reg != '0))
        else $error("element beat with bad status or empty list");
`endif

endmodule

/* bench/plsu_reply_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the list store. It keeps a shadow copy of the list,
// works out the replies that each accepted request should give, and matches
// each result beat against the oldest reply still owed.
module plsu_reply_checker
    import plsu_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int S_W         = 48,
    parameter int M_W         = 48
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [S_W-1:0] s_tdata,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [M_W-1:0] m_tdata,
    input  logic           m_tuser,
    input  logic           m_tlast,
    output int             mismatches,
    output int             replies_pending
);

    localparam int POS_W = $clog2(MAX_ENTRIES + 1);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] element;
        logic              element_valid;
        logic [POS_W-1:0]  count;
        logic              is_empty;
        logic              last;
    } list_reply_t;

    logic [DATA_W-1:0] shadow_list [MAX_ENTRIES];
    int unsigned       shadow_len = 0;
    list_reply_t       replies_due [$];
    int                fail_total = 0;

    task automatic owe_reply(input logic [STAT_W-1:0] status,
                             input logic [DATA_W-1:0] element,
                             input logic element_valid, input logic last);
        list_reply_t r;
        r.status        = status;
        r.element       = element;
        r.element_valid = element_valid;
        r.count         = POS_W'(shadow_len);
        r.is_empty      = (shadow_len == 0);
        r.last          = last;
        replies_due.push_back(r);
    endtask

    // Applies one request to the shadow list and queues what it should give.
    task automatic apply_request(input logic [REQ_W-1:0] kind,
                                 input logic [POS_W-1:0] pos,
                                 input logic [DATA_W-1:0] val);
        int i;
        int j;
        logic [DATA_W-1:0] key;
        case (kind)
            REQ_INSERT: begin
                // a bad position wins over a full list
                if (pos > shadow_len) begin
                    owe_reply(STAT_BAD_POS, '0, 1'b0, 1'b1);
                end else if (shadow_len >= MAX_ENTRIES) begin
                    owe_reply(STAT_FULL, '0, 1'b0, 1'b1);
                end else begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = val;
                    shadow_len++;
                    owe_reply(STAT_OK, '0, 1'b0, 1'b1);
                end
            end
            REQ_ERASE: begin
                if (pos >= shadow_len) begin
                    owe_reply(STAT_BAD_POS, '0, 1'b0, 1'b1);
                end else begin
                    for (i = pos; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                    owe_reply(STAT_OK, '0, 1'b0, 1'b1);
                end
            end
            REQ_SORT: begin
                // stable ascending sort, signed compare
                for (i = 1; i < shadow_len; i++) begin
                    key = shadow_list[i];
                    j = i;
                    while (j > 0 && $signed(shadow_list[j-1]) > $signed(key)) begin
                        shadow_list[j] = shadow_list[j-1];
                        j--;
                    end
                    shadow_list[j] = key;
                end
                owe_reply(STAT_OK, '0, 1'b0, 1'b1);
            end
            default: begin
                if (shadow_len == 0) begin
                    owe_reply(STAT_OK, '0, 1'b0, 1'b1);
                end else begin
                    for (i = 0; i < shadow_len; i++)
                        owe_reply(STAT_OK, shadow_list[i], 1'b1, i + 1 == shadow_len);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge aclk) begin
        list_reply_t want;
        if (!aresetn) begin
            shadow_len = 0;
            replies_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                apply_request(s_tdata[REQ_W-1:0], s_tdata[REQ_W +: POS_W],
                              s_tdata[REQ_W+POS_W +: DATA_W]);
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $error("result beat with no reply owed");
                    fail_total++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("status", DATA_W'(want.status), DATA_W'(m_tdata[STAT_W-1:0]));
                    check_field("element", want.element, m_tdata[STAT_W +: DATA_W]);
                    check_field("element_valid", DATA_W'(want.element_valid), DATA_W'(m_tuser));
                    check_field("count", DATA_W'(want.count),
                                DATA_W'(m_tdata[STAT_W+DATA_W +: POS_W]));
                    check_field("is_empty", DATA_W'(want.is_empty),
                                DATA_W'(m_tdata[STAT_W+DATA_W+POS_W]));
                    check_field("last", DATA_W'(want.last), DATA_W'(m_tlast));
                end
            end
        end
        mismatches      <= fail_total;
        replies_pending <= replies_due.size();
    end

endmodule

/* bench/positional_list_store_unit_test.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the list store. Checking lives in plsu_reply_checker.
module positional_list_store_unit_test;
    import plsu_pkg::*;

    localparam int MAX_ENTRIES  = 64;
    localparam int POS_W        = $clog2(MAX_ENTRIES + 1);
    localparam int S_W          = ((REQ_W + POS_W + DATA_W + 7) / 8) * 8;
    localparam int M_W          = ((STAT_W + DATA_W + POS_W + 1 + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_CYCLES  = 400;     // long receiver stall, fills the block
    localparam int CYCLE_LIMIT  = 600000;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;       // req_type, position, value
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;             // status, element, count, is_empty
    logic           m_tuser;             // element_valid
    logic           m_tlast;

    int          mismatches;
    int          replies_pending;
    int unsigned cycle_count  = 0;
    int unsigned entries_held = 0;       // list length as the requests leave it
    int          burst_left   = 0;
    bit          hold_wanted  = 1'b0;

    positional_list_store_unit #(.MAX_ENTRIES(MAX_ENTRIES)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    plsu_reply_checker #(.MAX_ENTRIES(MAX_ENTRIES), .S_W(S_W), .M_W(M_W)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .replies_pending (replies_pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: runs of always-ready, coin-toss, mostly-stalled and mostly-ready beats,
    // plus one long hold-off once the random requests start.
    initial begin
        int mode;
        int run;
        int k;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(1, 60);
            for (k = 0; k < run; k++) begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // Offers one request beat and waits for it to be taken, then keeps
    // the burst going or drops tvalid for a random gap.
    task automatic offer(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                         input logic [DATA_W-1:0] val);
        int gap;
        s_tdata  <= S_W'({val, pos, kind});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        case (kind)
            REQ_INSERT: if (pos <= entries_held && entries_held < MAX_ENTRIES) entries_held++;
            REQ_ERASE:  if (pos < entries_held) entries_held--;
            default: ;
        endcase
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Extremes, small values (so that equal keys turn up) and plain random.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return DATA_W'($urandom_range(0, 6) - 3);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int n;
        int pick;
        bit growing;
        logic [REQ_W-1:0] kind;
        logic [POS_W-1:0] pos;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty-list corners, extremes, bad positions, tail/head erase
        offer(REQ_DUMP,   0,   $urandom);       // dump of an empty list
        offer(REQ_ERASE,  0,   $urandom);       // erase from an empty list
        offer(REQ_INSERT, 1,   32'd5);          // insert past the end
        offer(REQ_SORT,   0,   $urandom);
        offer(REQ_INSERT, 0,   32'h7FFF_FFFF);
        offer(REQ_INSERT, 0,   32'h8000_0000);
        offer(REQ_INSERT, 2,   32'h0000_0000);  // append at the tail
        offer(REQ_INSERT, 1,   32'hFFFF_FFFF);
        offer(REQ_INSERT, 5,   32'd9);          // one past the end
        offer(REQ_INSERT, 127, 32'd9);          // every position bit set
        offer(REQ_DUMP,   127, $urandom);
        offer(REQ_SORT,   0,   $urandom);
        offer(REQ_DUMP,   0,   $urandom);
        offer(REQ_ERASE,  4,   $urandom);       // position equal to count
        offer(REQ_ERASE,  3,   $urandom);       // tail
        offer(REQ_ERASE,  0,   $urandom);       // head
        offer(REQ_INSERT, 1,   32'd1);
        offer(REQ_INSERT, 0,   32'd1);          // equal keys
        offer(REQ_INSERT, 0,   32'hFFFF_FFFE);
        offer(REQ_SORT,   64,  $urandom);
        offer(REQ_DUMP,   0,   $urandom);
        offer(REQ_ERASE,  127, $urandom);
        offer(REQ_DUMP,   0,   $urandom);

        // random: grow towards full, knock on a full list, shrink to empty, repeat
        hold_wanted = 1'b1;
        growing = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (growing && entries_held == MAX_ENTRIES && $urandom_range(0, 3) == 0)
                growing = 1'b0;
            else if (!growing && entries_held == 0)
                growing = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                kind = REQ_SORT;
            else if (pick < 16)
                kind = REQ_DUMP;
            else if (pick < (growing ? 76 : 36))
                kind = REQ_INSERT;
            else
                kind = REQ_ERASE;
            if ($urandom_range(0, 9) == 0)
                pos = POS_W'($urandom_range(0, 127));
            else if (kind == REQ_ERASE)
                pos = (entries_held == 0) ? '0 : POS_W'($urandom_range(0, entries_held - 1));
            else
                pos = POS_W'($urandom_range(0, entries_held));
            offer(kind, pos, pick_value());
        end
        s_tvalid <= 1'b0;

        // let the last replies drain, then give a sort time to finish
        @(posedge aclk);
        while (replies_pending != 0) @(posedge aclk);
        repeat (2 * MAX_ENTRIES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
